### src/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and codes of the MIDI track event parser: parser phases,
// result kinds, status and meta codes, and the result record.
// ----------------------------------------------------------------------------
package mtep_pkg;

  // Parser phase, one-hot
  typedef enum logic [15:0] {
    PH_DELTA    = 16'h0001,
    PH_STATUS   = 16'h0002,
    PH_PARAM1   = 16'h0004,
    PH_PARAM2   = 16'h0008,
    PH_SYSLEN   = 16'h0010,
    PH_SYSDATA  = 16'h0020,
    PH_METATYPE = 16'h0040,
    PH_METALEN  = 16'h0080,
    PH_TEMPO1   = 16'h0100,
    PH_TEMPO2   = 16'h0200,
    PH_TEMPO3   = 16'h0400,
    PH_KEY1     = 16'h0800,
    PH_KEY2     = 16'h1000,
    PH_SKIP     = 16'h2000,
    PH_DONE     = 16'h4000,
    PH_FAIL     = 16'h8000
  } phase_t;

  // Result kinds that are not channel messages
  localparam logic [3:0] KIND_SYSEX  = 4'd7;
  localparam logic [3:0] KIND_TEMPO  = 4'd8;
  localparam logic [3:0] KIND_END    = 4'd9;
  localparam logic [3:0] KIND_ERROR  = 4'd10;
  localparam logic [3:0] KIND_KEYSIG = 4'd11;

  // Status bytes and nibbles
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_CHANPRESS = 4'hD;

  // Meta event types
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] META_PORT   = 8'h21;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_KEYSIG = 8'h59;

  // Result queue depth
  localparam int unsigned RQ_DEPTH = 4;

  typedef struct packed {
    logic [3:0]         kind;
    logic [3:0]         channel;
    logic [6:0]         param_one;
    logic [6:0]         param_two;
    logic [31:0]        tick;
    logic [23:0]        tempo_value;
    logic [7:0]         sysex_byte;
    logic               sysex_end;
    logic signed [7:0]  key_sharps;
    logic               key_is_minor;
    logic               run_end;
  } result_t;

  // Results of one byte, packed to the front: r0 first
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

endpackage

### src/midi_track_event_parser_core.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser_core
// Byte-serial parser for the event stream of a standard MIDI file track.
// ----------------------------------------------------------------------------
// Feed track chunk payload bytes one per item, marking the final byte with
// track_last. The core takes one byte every cycle unless in_stall is high:
// the whole update of the parser state for a byte is one pass of logic, and
// its results go into a four-entry result queue that drives the output
// ports. Most bytes give no result or one; the final byte of a track can
// give two (the event it completes and a missing-end-of-track error). The
// input stalls only while fewer than two queue entries are free, so with
// the output side draining every cycle the input never stalls for long.
// run_end marks the last result of each byte. smpte_mode
// is written through the cfg channel, which is always ready; write it
// only while the core is idle. Absolute ticks wrap at 2^TICK_BITS and the
// tick port shows the low 32 bits.
// ----------------------------------------------------------------------------
module midi_track_event_parser_core #(
  parameter int TICK_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  // input item channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               track_last,
  // result item channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         kind,
  output logic [3:0]         channel,
  output logic [6:0]         param_one,
  output logic [6:0]         param_two,
  output logic [31:0]        tick,
  output logic [23:0]        tempo_value,
  output logic [7:0]         sysex_byte,
  output logic               sysex_end,
  output logic signed [7:0]  key_sharps,
  output logic               key_is_minor,
  output logic               run_end
);
  import mtep_pkg::*;

  logic         smpte_mode;
  logic         in_accept;
  logic         q_full;
  result_pair_t results;
  result_t      head;

  // Configuration register: always ready, skip tempo events when set
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      smpte_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      smpte_mode <= cfg_data;
    end
  end

  // Hold input while the queue cannot absorb a worst-case pair of results
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  mtep_parser #(
    .TICK_BITS (TICK_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .data_byte  (data_byte),
    .track_last (track_last),
    .smpte_mode (smpte_mode),
    .results    (results)
  );

  // Queue results; advance the head when the output side takes it
  mtep_result_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .push          (in_accept),
    .push_data     (results),
    .pop           (!out_stall),
    .head          (head),
    .not_empty     (out_valid),
    .full_for_pair (q_full)
  );

  assign kind         = head.kind;
  assign channel      = head.channel;
  assign param_one    = head.param_one;
  assign param_two    = head.param_two;
  assign tick         = head.tick;
  assign tempo_value  = head.tempo_value;
  assign sysex_byte   = head.sysex_byte;
  assign sysex_end    = head.sysex_end;
  assign key_sharps   = head.key_sharps;
  assign key_is_minor = head.key_is_minor;
  assign run_end      = head.run_end;

endmodule

### src/mtep_parser.sv
// ----------------------------------------------------------------------------
// mtep_parser
// Parser state and one-byte update; yields up to two results per byte.
// ----------------------------------------------------------------------------
module mtep_parser #(
  parameter int TICK_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  track_last,
  input  logic                  smpte_mode,
  output mtep_pkg::result_pair_t results
);
  import mtep_pkg::*;

  phase_t                phase, phase_next, phase_work;
  logic [TICK_BITS-1:0]  tick_total, tick_next, tick_work;
  logic [7:0]            running_status, running_status_next;
  logic [7:0]            current_status, current_status_next;
  logic [27:0]           varlen_accum, varlen_accum_next;
  logic [1:0]            varlen_count, varlen_count_next;
  logic [27:0]           bytes_left, bytes_left_next;
  logic [6:0]            first_param, first_param_next;
  logic [7:0]            meta_type, meta_type_next;
  logic [23:0]           tempo_accum, tempo_accum_next;
  logic [7:0]            key_sharps_hold, key_sharps_hold_next;

  logic [27:0]           vl_acc;
  logic                  vl_done, vl_bad;
  logic [27:0]           bl_dec;
  logic [3:0]            st_hi;
  logic [7:0]            fd_status;
  logic                  fd_en;
  logic                  ev_vld;
  result_t               ev;
  logic                  miss_end;
  logic [TICK_BITS+31:0] tick_ext;
  logic [31:0]           tick32;
  result_t               err_res;

  assign vl_acc   = {varlen_accum[20:0], data_byte[6:0]};
  assign vl_done  = !data_byte[7];
  assign vl_bad   = data_byte[7] && (varlen_count == 2'd3);
  assign bl_dec   = (bytes_left != '0) ? bytes_left - 28'd1 : '0;
  assign tick_ext = {32'd0, tick_work};
  assign tick32   = tick_ext[31:0];

  always_comb begin
    phase_work           = phase;
    tick_work            = tick_total;
    running_status_next  = running_status;
    current_status_next  = current_status;
    varlen_accum_next    = varlen_accum;
    varlen_count_next    = varlen_count;
    bytes_left_next      = bytes_left;
    first_param_next     = first_param;
    meta_type_next       = meta_type;
    tempo_accum_next     = tempo_accum;
    key_sharps_hold_next = key_sharps_hold;
    ev_vld               = 1'b0;
    ev                   = '0;
    fd_en                = 1'b0;
    fd_status            = current_status;

    case (phase)
      PH_DELTA: begin
        varlen_accum_next = vl_acc;
        if (vl_bad) begin
          ev_vld     = 1'b1;
          ev.kind    = KIND_ERROR;
          phase_work = PH_FAIL;
        end else if (vl_done) begin
          tick_work         = tick_total + TICK_BITS'(vl_acc);
          varlen_accum_next = '0;
          varlen_count_next = '0;
          phase_work        = PH_STATUS;
        end else begin
          varlen_count_next = varlen_count + 2'd1;
        end
      end
      PH_STATUS: begin
        if (data_byte[7]) begin
          current_status_next = data_byte;
          if (data_byte < ST_SYSEX) begin
            running_status_next = data_byte;
            phase_work          = PH_PARAM1;
          end else if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_ESC) begin
            phase_work = PH_SYSLEN;
          end else if (data_byte == ST_META) begin
            phase_work = PH_METATYPE;
          end else begin
            ev_vld     = 1'b1;
            ev.kind    = KIND_ERROR;
            phase_work = PH_FAIL;
          end
        end else if (running_status == '0) begin
          ev_vld     = 1'b1;
          ev.kind    = KIND_ERROR;
          phase_work = PH_FAIL;
        end else begin
          current_status_next = running_status;
          fd_status           = running_status;
          fd_en               = 1'b1;
        end
      end
      PH_PARAM1: begin
        fd_en = 1'b1;
      end
      PH_PARAM2: begin
        ev_vld       = 1'b1;
        ev.kind      = {1'b0, current_status[6:4]};
        ev.channel   = current_status[3:0];
        ev.param_one = first_param;
        ev.param_two = data_byte[6:0];
        phase_work   = PH_DELTA;
      end
      PH_SYSLEN: begin
        if (vl_bad) begin
          varlen_accum_next = vl_acc;
          ev_vld            = 1'b1;
          ev.kind           = KIND_ERROR;
          phase_work        = PH_FAIL;
        end else if (vl_done) begin
          varlen_accum_next = '0;
          varlen_count_next = '0;
          if (current_status == ST_SYSEX) begin
            ev_vld        = 1'b1;
            ev.kind       = KIND_SYSEX;
            ev.sysex_byte = ST_SYSEX;
            ev.sysex_end  = (vl_acc == '0);
          end else if (vl_acc == '0) begin
            ev_vld       = 1'b1;
            ev.kind      = KIND_SYSEX;
            ev.sysex_end = 1'b1;
          end
          bytes_left_next = vl_acc;
          phase_work      = (vl_acc != '0) ? PH_SYSDATA : PH_DELTA;
        end else begin
          varlen_accum_next = vl_acc;
          varlen_count_next = varlen_count + 2'd1;
        end
      end
      PH_SYSDATA: begin
        bytes_left_next = bl_dec;
        ev_vld          = 1'b1;
        ev.kind         = KIND_SYSEX;
        ev.sysex_byte   = data_byte;
        ev.sysex_end    = (bl_dec == '0);
        if (bl_dec == '0) begin
          phase_work = PH_DELTA;
        end
      end
      PH_METATYPE: begin
        meta_type_next = data_byte;
        phase_work     = PH_METALEN;
      end
      PH_METALEN: begin
        if (vl_bad) begin
          varlen_accum_next = vl_acc;
          ev_vld            = 1'b1;
          ev.kind           = KIND_ERROR;
          phase_work        = PH_FAIL;
        end else if (vl_done) begin
          varlen_accum_next = '0;
          varlen_count_next = '0;
          bytes_left_next   = vl_acc;
          phase_work        = (vl_acc != '0) ? PH_SKIP : PH_DELTA;
          if (meta_type == META_EOT) begin
            ev_vld     = 1'b1;
            ev.kind    = KIND_END;
            phase_work = PH_DONE;
          end else if ((meta_type == META_PORT && vl_acc < 28'd1) ||
                       (meta_type == META_TEMPO && vl_acc < 28'd3) ||
                       (meta_type == META_KEYSIG && vl_acc < 28'd2)) begin
            ev_vld     = 1'b1;
            ev.kind    = KIND_ERROR;
            phase_work = PH_FAIL;
          end else if (meta_type == META_TEMPO && !smpte_mode) begin
            phase_work = PH_TEMPO1;
          end else if (meta_type == META_KEYSIG) begin
            phase_work = PH_KEY1;
          end
        end else begin
          varlen_accum_next = vl_acc;
          varlen_count_next = varlen_count + 2'd1;
        end
      end
      PH_TEMPO1, PH_TEMPO2: begin
        tempo_accum_next = {tempo_accum[15:0], data_byte};
        bytes_left_next  = bl_dec;
        phase_work       = (phase == PH_TEMPO1) ? PH_TEMPO2 : PH_TEMPO3;
      end
      PH_TEMPO3: begin
        tempo_accum_next = {tempo_accum[15:0], data_byte};
        bytes_left_next  = bl_dec;
        ev_vld           = 1'b1;
        ev.kind          = KIND_TEMPO;
        ev.tempo_value   = {tempo_accum[15:0], data_byte};
        phase_work       = (bl_dec != '0) ? PH_SKIP : PH_DELTA;
      end
      PH_KEY1: begin
        key_sharps_hold_next = data_byte;
        bytes_left_next      = bl_dec;
        phase_work           = PH_KEY2;
      end
      PH_KEY2: begin
        bytes_left_next = bl_dec;
        ev_vld          = 1'b1;
        ev.kind         = KIND_KEYSIG;
        ev.key_sharps   = key_sharps_hold;
        ev.key_is_minor = (data_byte != '0);
        phase_work      = (bl_dec != '0) ? PH_SKIP : PH_DELTA;
      end
      PH_SKIP: begin
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          phase_work = PH_DELTA;
        end
      end
      default: begin
      end
    endcase

    // First data byte of a channel message
    st_hi = fd_status[7:4];
    if (fd_en) begin
      if (st_hi == HI_PROGRAM || st_hi == HI_CHANPRESS) begin
        ev_vld       = 1'b1;
        ev.kind      = {1'b0, st_hi[2:0]};
        ev.channel   = fd_status[3:0];
        ev.param_one = data_byte[6:0];
        phase_work   = PH_DELTA;
      end else begin
        first_param_next = data_byte[6:0];
        phase_work       = PH_PARAM2;
      end
    end

    // Track ends: flag a missing end of track, then restart
    miss_end   = track_last && phase_work != PH_DONE && phase_work != PH_FAIL;
    phase_next = phase_work;
    tick_next  = tick_work;
    if (track_last) begin
      phase_next           = PH_DELTA;
      tick_next            = '0;
      running_status_next  = '0;
      current_status_next  = '0;
      varlen_accum_next    = '0;
      varlen_count_next    = '0;
      bytes_left_next      = '0;
      first_param_next     = '0;
      meta_type_next       = '0;
      tempo_accum_next     = '0;
      key_sharps_hold_next = '0;
    end
  end

  always_comb begin
    err_res         = '0;
    err_res.kind    = KIND_ERROR;
    err_res.tick    = tick32;
    err_res.run_end = 1'b1;
    results         = '0;
    if (ev_vld) begin
      results.r0         = ev;
      results.r0.tick    = tick32;
      results.r0.run_end = !miss_end;
      results.r1         = err_res;
      results.cnt        = miss_end ? 2'd2 : 2'd1;
    end else if (miss_end) begin
      results.r0  = err_res;
      results.cnt = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_DELTA;
      tick_total      <= '0;
      running_status  <= '0;
      current_status  <= '0;
      varlen_accum    <= '0;
      varlen_count    <= '0;
      bytes_left      <= '0;
      first_param     <= '0;
      meta_type       <= '0;
      tempo_accum     <= '0;
      key_sharps_hold <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      tick_total      <= tick_next;
      running_status  <= running_status_next;
      current_status  <= current_status_next;
      varlen_accum    <= varlen_accum_next;
      varlen_count    <= varlen_count_next;
      bytes_left      <= bytes_left_next;
      first_param     <= first_param_next;
      meta_type       <= meta_type_next;
      tempo_accum     <= tempo_accum_next;
      key_sharps_hold <= key_sharps_hold_next;
    end
  end

endmodule

### src/mtep_result_queue.sv
// ----------------------------------------------------------------------------
// mtep_result_queue
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module mtep_result_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  mtep_pkg::result_pair_t push_data,
  input  logic                   pop,
  output mtep_pkg::result_t      head,
  output logic                   not_empty,
  output logic                   full_for_pair
);
  import mtep_pkg::*;

  localparam int PW = $clog2(RQ_DEPTH);
  localparam int CW = $clog2(RQ_DEPTH + 1);

  result_t         entries [RQ_DEPTH];
  logic [PW-1:0]   wr_ptr, wr_ptr_next;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   push_cnt;
  logic            do_pop;

  assign not_empty     = (count != '0);
  assign full_for_pair = (count > CW'(RQ_DEPTH - 2));
  assign head          = entries[rd_ptr];
  assign do_pop        = pop && not_empty;
  assign push_cnt      = push ? CW'(push_data.cnt) : '0;
  assign wr_ptr_next   = wr_ptr + PW'(1);

  always_ff @(posedge clk) begin
    if (push && push_data.cnt != 2'd0) begin
      entries[wr_ptr] <= push_data.r0;
    end
    if (push && push_data.cnt == 2'd2) begin
      entries[wr_ptr_next] <= push_data.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_cnt);
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + push_cnt - CW'(do_pop);
    end
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb - track event parser testbench
// Streams MIDI track chunk bytes into midi_track_event_parser_core: a short
// directed set of tracks, then random tracks that are mostly well formed,
// with noise, truncated tracks and bad encodings mixed in. A parser model
// inside the testbench predicts every result of each accepted byte, and
// each result leaving the core is compared field by field with the oldest
// prediction. Both sides idle and stall at random, and the SMPTE timing
// register is switched between blocks of tracks while the core is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtep_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;

  // Outcome of one byte of a variable-length quantity
  typedef enum logic [1:0] {
    VLQ_MORE,
    VLQ_DONE,
    VLQ_BAD
  } vlq_step_t;

  // One byte waiting to be driven; hold asks the driver to wait until
  // every predicted event has come out before it offers this byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hold;
  } feed_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        data_byte = 8'd0;
  logic              track_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [3:0]        kind;
  logic [3:0]        channel;
  logic [6:0]        param_one;
  logic [6:0]        param_two;
  logic [31:0]       tick;
  logic [23:0]       tempo_value;
  logic [7:0]        sysex_byte;
  logic              sysex_end;
  logic signed [7:0] key_sharps;
  logic              key_is_minor;
  logic              run_end;

  // Bytes waiting for the driver, the chunk under construction, and the
  // events the parser model says must still come out, oldest first
  feed_item_t track_bytes[$];
  logic [7:0] chunk[$];
  result_t    parsed_events[$];
  result_t    byte_events[$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  block_bytes = 0;
  bit  calm_run = 1'b0;
  logic [7:0] gen_running = 8'd0;

  // Parser model state
  phase_t      pr_phase = PH_DELTA;
  logic [31:0] pr_tick = '0;
  logic [7:0]  pr_running = '0;
  logic [7:0]  pr_status = '0;
  logic [27:0] pr_vlq = '0;
  logic [1:0]  pr_vlq_cnt = '0;
  logic [27:0] pr_remain = '0;
  logic [6:0]  pr_first = '0;
  logic [7:0]  pr_meta = '0;
  logic [23:0] pr_tempo = '0;
  logic [7:0]  pr_sharps = '0;
  logic        pr_smpte = 1'b0;

  midi_track_event_parser_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .track_last   (track_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .channel      (channel),
    .param_one    (param_one),
    .param_two    (param_two),
    .tick         (tick),
    .tempo_value  (tempo_value),
    .sysex_byte   (sysex_byte),
    .sysex_end    (sysex_end),
    .key_sharps   (key_sharps),
    .key_is_minor (key_is_minor),
    .run_end      (run_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------

  // Start a result of the given kind at the tick reached so far
  function automatic result_t blank_event(input logic [3:0] k);
    result_t r;
    r = '0;
    r.kind = k;
    r.tick = pr_tick;
    return r;
  endfunction

  // Channel message from the current status; kind follows the high nibble
  function automatic result_t chan_event(input logic [6:0] pa, input logic [6:0] pb);
    result_t r;
    r = blank_event(pr_status[7:4] - 4'd8);
    r.channel = pr_status[3:0];
    r.param_one = pa;
    r.param_two = pb;
    return r;
  endfunction

  task automatic push_event(input result_t r);
    if (byte_events.size() < 2) byte_events.insert(byte_events.size(), r);
  endtask

  // Report an error and ignore everything up to the end of the track
  task automatic raise_error();
    push_event(blank_event(KIND_ERROR));
    pr_phase = PH_FAIL;
  endtask

  // Shift in seven bits; a fourth byte that still continues is bad
  function automatic vlq_step_t take_vlq(input logic [7:0] b);
    pr_vlq = {pr_vlq[20:0], b[6:0]};
    if (!b[7]) return VLQ_DONE;
    if (pr_vlq_cnt == 2'd3) return VLQ_BAD;
    pr_vlq_cnt = pr_vlq_cnt + 2'd1;
    return VLQ_MORE;
  endfunction

  task automatic start_skip(input logic [27:0] len);
    pr_remain = len;
    pr_phase = (len != 0) ? PH_SKIP : PH_DELTA;
  endtask

  // First data byte: program and channel pressure finish here
  task automatic first_data(input logic [7:0] b);
    if (pr_status[7:4] == HI_PROGRAM || pr_status[7:4] == HI_CHANPRESS) begin
      push_event(chan_event(b[6:0], 7'd0));
      pr_phase = PH_DELTA;
    end else begin
      pr_first = b[6:0];
      pr_phase = PH_PARAM2;
    end
  endtask

  task automatic clear_track();
    pr_phase = PH_DELTA;
    pr_tick = '0;
    pr_running = '0;
    pr_status = '0;
    pr_vlq = '0;
    pr_vlq_cnt = '0;
    pr_remain = '0;
    pr_first = '0;
    pr_meta = '0;
    pr_tempo = '0;
    pr_sharps = '0;
  endtask

  // Advance the model by one accepted byte and queue the events it gives
  task automatic parse_byte(input logic [7:0] b, input logic last);
    vlq_step_t   st;
    logic [27:0] len;
    result_t     r;
    byte_events.delete();
    case (pr_phase)
      PH_DELTA: begin
        st = take_vlq(b);
        if (st == VLQ_BAD) begin
          raise_error();
        end else if (st == VLQ_DONE) begin
          pr_tick = pr_tick + {4'd0, pr_vlq};
          pr_vlq = '0;
          pr_vlq_cnt = '0;
          pr_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          pr_status = b;
          if (b < ST_SYSEX) begin
            pr_running = b;
            pr_phase = PH_PARAM1;
          end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
            pr_phase = PH_SYSLEN;
          end else if (b == ST_META) begin
            pr_phase = PH_METATYPE;
          end else begin
            raise_error();
          end
        end else if (pr_running == 8'd0) begin
          raise_error();
        end else begin
          pr_status = pr_running;
          first_data(b);
        end
      end
      PH_PARAM1: first_data(b);
      PH_PARAM2: begin
        push_event(chan_event(pr_first, b[6:0]));
        pr_phase = PH_DELTA;
      end
      PH_SYSLEN: begin
        st = take_vlq(b);
        if (st == VLQ_BAD) begin
          raise_error();
        end else if (st == VLQ_DONE) begin
          len = pr_vlq;
          pr_vlq = '0;
          pr_vlq_cnt = '0;
          if (pr_status == ST_SYSEX) begin
            r = blank_event(KIND_SYSEX);
            r.sysex_byte = ST_SYSEX;
            r.sysex_end = (len == 0);
            push_event(r);
          end else if (len == 0) begin
            r = blank_event(KIND_SYSEX);
            r.sysex_end = 1'b1;
            push_event(r);
          end
          pr_remain = len;
          pr_phase = (len != 0) ? PH_SYSDATA : PH_DELTA;
        end
      end
      PH_SYSDATA: begin
        if (pr_remain != 0) pr_remain = pr_remain - 28'd1;
        r = blank_event(KIND_SYSEX);
        r.sysex_byte = b;
        r.sysex_end = (pr_remain == 0);
        push_event(r);
        if (pr_remain == 0) pr_phase = PH_DELTA;
      end
      PH_METATYPE: begin
        pr_meta = b;
        pr_phase = PH_METALEN;
      end
      PH_METALEN: begin
        st = take_vlq(b);
        if (st == VLQ_BAD) begin
          raise_error();
        end else if (st == VLQ_DONE) begin
          len = pr_vlq;
          pr_vlq = '0;
          pr_vlq_cnt = '0;
          if (pr_meta == META_EOT) begin
            push_event(blank_event(KIND_END));
            pr_phase = PH_DONE;
          end else if (pr_meta == META_PORT) begin
            if (len < 1) raise_error();
            else start_skip(len);
          end else if (pr_meta == META_TEMPO) begin
            if (len < 3) begin
              raise_error();
            end else if (pr_smpte) begin
              start_skip(len);
            end else begin
              pr_remain = len;
              pr_phase = PH_TEMPO1;
            end
          end else if (pr_meta == META_KEYSIG) begin
            if (len < 2) begin
              raise_error();
            end else begin
              pr_remain = len;
              pr_phase = PH_KEY1;
            end
          end else begin
            start_skip(len);
          end
        end
      end
      PH_TEMPO1, PH_TEMPO2, PH_TEMPO3: begin
        pr_tempo = {pr_tempo[15:0], b};
        if (pr_remain != 0) pr_remain = pr_remain - 28'd1;
        if (pr_phase == PH_TEMPO3) begin
          r = blank_event(KIND_TEMPO);
          r.tempo_value = pr_tempo;
          push_event(r);
          start_skip(pr_remain);
        end else if (pr_phase == PH_TEMPO1) begin
          pr_phase = PH_TEMPO2;
        end else begin
          pr_phase = PH_TEMPO3;
        end
      end
      PH_KEY1: begin
        pr_sharps = b;
        if (pr_remain != 0) pr_remain = pr_remain - 28'd1;
        pr_phase = PH_KEY2;
      end
      PH_KEY2: begin
        if (pr_remain != 0) pr_remain = pr_remain - 28'd1;
        r = blank_event(KIND_KEYSIG);
        r.key_sharps = pr_sharps;
        r.key_is_minor = (b != 8'd0);
        push_event(r);
        start_skip(pr_remain);
      end
      PH_SKIP: begin
        if (pr_remain != 0) pr_remain = pr_remain - 28'd1;
        if (pr_remain == 0) pr_phase = PH_DELTA;
      end
      default: ;
    endcase
    // A chunk that ends without end of track and without an earlier error
    // owes one more error after whatever this byte gave
    if (last) begin
      if (pr_phase != PH_DONE && pr_phase != PH_FAIL) push_event(blank_event(KIND_ERROR));
      clear_track();
    end
    if (byte_events.size() > 0) begin
      r = byte_events[byte_events.size() - 1];
      r.run_end = 1'b1;
      byte_events[byte_events.size() - 1] = r;
    end
    foreach (byte_events[i]) parsed_events.insert(parsed_events.size(), byte_events[i]);
  endtask

  task automatic check_event(input result_t want, input result_t got);
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatch_count++;
    end
    if (got.channel !== want.channel) begin
      $error("channel: expected %0d, got %0d", want.channel, got.channel);
      mismatch_count++;
    end
    if (got.param_one !== want.param_one) begin
      $error("param_one: expected %0d, got %0d", want.param_one, got.param_one);
      mismatch_count++;
    end
    if (got.param_two !== want.param_two) begin
      $error("param_two: expected %0d, got %0d", want.param_two, got.param_two);
      mismatch_count++;
    end
    if (got.tick !== want.tick) begin
      $error("tick: expected %0d, got %0d", want.tick, got.tick);
      mismatch_count++;
    end
    if (got.tempo_value !== want.tempo_value) begin
      $error("tempo_value: expected %0d, got %0d", want.tempo_value, got.tempo_value);
      mismatch_count++;
    end
    if (got.sysex_byte !== want.sysex_byte) begin
      $error("sysex_byte: expected %0d, got %0d", want.sysex_byte, got.sysex_byte);
      mismatch_count++;
    end
    if (got.sysex_end !== want.sysex_end) begin
      $error("sysex_end: expected %0d, got %0d", want.sysex_end, got.sysex_end);
      mismatch_count++;
    end
    if (got.key_sharps !== want.key_sharps) begin
      $error("key_sharps: expected %0d, got %0d", want.key_sharps, got.key_sharps);
      mismatch_count++;
    end
    if (got.key_is_minor !== want.key_is_minor) begin
      $error("key_is_minor: expected %0d, got %0d", want.key_is_minor, got.key_is_minor);
      mismatch_count++;
    end
    if (got.run_end !== want.run_end) begin
      $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer the next byte once the current one is taken. Idle now and
  // then, except in the calm block. A held byte waits for an idle cycle and
  // an empty event queue, so the core drains completely first.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    feed_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (track_bytes.size() != 0 && !(!calm_run && $urandom_range(0, 99) < 14) &&
          !(track_bytes[0].hold && (in_valid || parsed_events.size() != 0))) begin
        nxt = track_bytes.pop_front();
        in_valid <= 1'b1;
        data_byte <= nxt.data;
        track_last <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict from each accepted byte first, then check the accepted
  // result against the oldest prediction. Stall the output at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t seen;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_byte(data_byte, track_last);
      if (out_valid && !out_stall) begin
        seen.kind = kind;
        seen.channel = channel;
        seen.param_one = param_one;
        seen.param_two = param_two;
        seen.tick = tick;
        seen.tempo_value = tempo_value;
        seen.sysex_byte = sysex_byte;
        seen.sysex_end = sysex_end;
        seen.key_sharps = key_sharps;
        seen.key_is_minor = key_is_minor;
        seen.run_end = run_end;
        if (parsed_events.size() == 0) begin
          $error("unexpected result: kind %0d tick %0d", seen.kind, seen.tick);
          mismatch_count++;
        end else begin
          check_event(parsed_events.pop_front(), seen);
        end
      end
      out_stall <= !calm_run && ($urandom_range(0, 99) < 14);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("midi_track_event_parser_core verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  task automatic put(input logic [7:0] b);
    chunk.insert(chunk.size(), b);
  endtask

  // Variable-length quantity, optionally padded with leading zero groups
  task automatic put_vlq(input int unsigned v, input bit pad);
    logic [6:0] grp[4];
    int n;
    n = 1;
    grp[0] = v[6:0];
    while (n < 4 && (v >> (7 * n)) != 0) begin
      grp[n] = 7'((v >> (7 * n)) & 32'h7F);
      n++;
    end
    if (pad) begin
      while (n < 4 && $urandom_range(0, 1) == 1) begin
        grp[n] = 7'd0;
        n++;
      end
    end
    for (int i = n - 1; i >= 0; i--) put({i != 0, grp[i]});
  endtask

  // Hand the chunk to the driver, marking its final byte
  task automatic send_chunk(input bit hold_first);
    feed_item_t it;
    foreach (chunk[i]) begin
      it.data = chunk[i];
      it.last = (i == chunk.size() - 1);
      it.hold = hold_first && (i == 0);
      track_bytes.insert(track_bytes.size(), it);
    end
    block_bytes += chunk.size();
    chunk.delete();
  endtask

  task automatic put_delta(input bit wrap);
    int r;
    r = $urandom_range(0, 99);
    if (wrap) begin
      put_vlq(32'h0FFF_FFFF, 1'b0);
    end else if (r < 3) begin
      // delta that never terminates within four bytes
      repeat (4) put(8'h80 | 8'($urandom_range(0, 127)));
    end else if (r < 65) begin
      put_vlq($urandom_range(0, 127), $urandom_range(0, 9) == 0);
    end else if (r < 90) begin
      put_vlq($urandom_range(0, 16383), $urandom_range(0, 3) == 0);
    end else begin
      put_vlq($urandom_range(0, 32'h0FFF_FFFF), 1'b0);
    end
  endtask

  // Parameter byte: mostly clean data, sometimes a status byte in disguise
  function automatic logic [7:0] rand_param();
    if ($urandom_range(0, 99) < 6) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic put_channel_msg();
    logic [7:0] st;
    logic [7:0] p1;
    if (gen_running != 8'd0 && $urandom_range(0, 1) == 1) begin
      // lean on running status: the first data byte must look like data
      st = gen_running;
      put(8'($urandom_range(0, 127)));
    end else begin
      st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
      p1 = rand_param();
      put(st);
      put(p1);
    end
    gen_running = st;
    if (st[7:4] != HI_PROGRAM && st[7:4] != HI_CHANPRESS) put(rand_param());
  endtask

  task automatic put_meta(input logic [7:0] mtype, input int len);
    put(ST_META);
    put(mtype);
    put_vlq(len, $urandom_range(0, 7) == 0);
    repeat (len) put(8'($urandom_range(0, 255)));
  endtask

  task automatic put_event(input bit brief);
    int roll;
    int len;
    roll = brief ? 0 : $urandom_range(0, 99);
    if (roll < 45) begin
      put_channel_msg();
    end else if (roll < 57) begin
      len = $urandom_range(0, 5);
      put(ST_SYSEX);
      put_vlq(len, $urandom_range(0, 7) == 0);
      repeat (len) put(8'($urandom_range(0, 255)));
    end else if (roll < 62) begin
      len = $urandom_range(0, 2);
      put(ST_SYSEX_ESC);
      put_vlq(len, 1'b0);
      repeat (len) put(8'($urandom_range(0, 255)));
    end else if (roll < 70) begin
      put_meta(META_TEMPO, $urandom_range(3, 5));
    end else if (roll < 78) begin
      put_meta(META_KEYSIG, $urandom_range(2, 3));
    end else if (roll < 83) begin
      put_meta(META_PORT, $urandom_range(1, 2));
    end else if (roll < 92) begin
      put_meta(8'($urandom_range(0, 255)), $urandom_range(0, 3));
    end else begin
      // malformed event
      case ($urandom_range(0, 3))
        0: begin
          put(ST_SYSEX);
          repeat (4) put(8'h80 | 8'($urandom_range(0, 127)));
        end
        1: begin
          roll = $urandom_range(8'hF1, 8'hFE);
          put((8'(roll) == ST_SYSEX_ESC) ? 8'hF1 : 8'(roll));
        end
        2: begin
          case ($urandom_range(0, 2))
            0: put_meta(META_TEMPO, $urandom_range(0, 2));
            1: put_meta(META_KEYSIG, $urandom_range(0, 1));
            default: put_meta(META_PORT, 0);
          endcase
        end
        default: begin
          put(ST_META);
          put(8'($urandom_range(0, 127)));
          repeat (4) put(8'h80 | 8'($urandom_range(0, 127)));
        end
      endcase
    end
  endtask

  // One track chunk: mostly well formed with random content, else noise,
  // a missing end of track, or a chunk cut short
  task automatic gen_track(input bit wrap, input bit hold_first);
    int roll;
    int tail;
    int n_events;
    chunk.delete();
    gen_running = 8'd0;
    roll = wrap ? 99 : $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
    end else begin
      // a data byte before any running status exists
      if (roll < 13) begin
        put_vlq($urandom_range(0, 127), 1'b0);
        put(8'($urandom_range(0, 127)));
      end
      n_events = wrap ? 17 : $urandom_range(1, 8);
      repeat (n_events) begin
        put_delta(wrap);
        put_event(wrap);
      end
      tail = $urandom_range(0, 99);
      if (tail < 80) begin
        put_vlq($urandom_range(0, 100), 1'b0);
        put(ST_META);
        put(META_EOT);
        put_vlq(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, 1'b0);
        // junk after the end is ignored until the chunk closes
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
      end else if (tail >= 90) begin
        repeat ($urandom_range(1, 3)) if (chunk.size() > 1) void'(chunk.pop_back());
      end
    end
    send_chunk(hold_first);
  endtask

  task automatic random_tracks(input int budget, input bit wrap_first, input bit hold_third);
    int k;
    k = 0;
    block_bytes = 0;
    while (block_bytes < budget) begin
      gen_track(wrap_first && k == 0, hold_third && k == 2);
      k++;
    end
  endtask

  // Hold until every byte is taken and every event is out, then let the
  // core finish bytes that give no event
  task automatic drain_and_settle(input int extra);
    while (track_bytes.size() != 0 || in_valid || parsed_events.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_smpte(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pr_smpte = v;
  endtask

  task automatic directed_tracks();
    // delta 0xFF, pitch bend on channel 15 with status-like parameters,
    // program change, tempo, empty F7 marker on the final byte: the marker
    // and the missing-end error come from the same byte
    put(8'h81); put(8'h7F); put(8'hEF); put(8'hFF); put(8'h80);
    put(8'h00); put(8'hC5); put(8'h00);
    put(8'h00); put(ST_META); put(META_TEMPO); put(8'h03);
    put(8'h07); put(8'hA1); put(8'h20);
    put(8'h00); put(ST_SYSEX_ESC); put(8'h00);
    send_chunk(1'b0);
    // bad status
    put(8'h00); put(8'hF2);
    send_chunk(1'b0);
    // delta too long
    repeat (4) put(8'h80);
    send_chunk(1'b0);
    // orphan data byte
    put(8'h00); put(8'h40);
    send_chunk(1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Block 1: tempo decoded; directed tracks, then a tick wrap track first
    write_smpte(1'b0);
    directed_tracks();
    random_tracks(90, 1'b1, 1'b0);
    drain_and_settle(SETTLE_CYCLES);

    // Block 2: SMPTE timing, no idling on either side
    write_smpte(1'b1);
    calm_run = 1'b1;
    random_tracks(90, 1'b0, 1'b0);
    drain_and_settle(SETTLE_CYCLES);
    calm_run = 1'b0;

    // Block 3: tempo decoded again; one track waits for a full drain
    write_smpte(1'b0);
    random_tracks(90, 1'b0, 1'b1);
    drain_and_settle(SETTLE_CYCLES);

    // Block 4: SMPTE timing with idling
    write_smpte(1'b1);
    random_tracks(90, 1'b0, 1'b0);
    drain_and_settle(DRAIN_CYCLES);

    if (mismatch_count == 0 && parsed_events.size() == 0) begin
      $display("midi_track_event_parser_core verification clean");
    end else begin
      $display("midi_track_event_parser_core verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/mtep_pkg.sv
src/mtep_parser.sv
src/mtep_result_queue.sv
src/midi_track_event_parser_core.sv
verif/tb.sv
